### hdl/fpri_pkg.sv
// Package for the floating-point round-to-integral block: modes, widths, constants.
package fpri_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_RNE = 3'd0,
        MODE_RTZ = 3'd1,
        MODE_RDN = 3'd2,
        MODE_RUP = 3'd3,
        MODE_RMM = 3'd4
    } t_round_mode;

    localparam logic [63:0] ONE_D = 64'h3FF0000000000000;
    localparam logic [31:0] ONE_S = 32'h3F800000;
    localparam logic [5:0]  MBITS_D = 6'd52;
    localparam logic [5:0]  MBITS_S = 6'd23;
    localparam logic [10:0] BIAS_D = 11'd1023;
    localparam logic [10:0] BIAS_S = 11'd127;

endpackage

### hdl/fp_round_to_integral.sv
// Top level: rounds binary32/binary64 encodings to integral values, one request per cycle.
// Each request goes from the input register through one pass of mask, compare and add
// logic into a result register. A new request is accepted
// every cycle; only a stalled result register with a full input register holds s_tready
// low. Rounding mode codes: 0 nearest-even, 1 toward zero, 2 down, 3 up, 4 nearest-max-
// magnitude, 5..7 take the mode written on i_cfg_wdata (dynamic mode register, reset 0).
// NaN payloads, infinities, zeros and large magnitudes pass through unchanged.
module fp_round_to_integral (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value_bits
    input  logic [3:0]  s_tuser,   // [0] is_double, [3:1] round_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] rounded_bits
);

    logic [2:0]  r_dyn_mode;
    logic        r_in_valid;
    logic [63:0] r_in_bits;
    logic        r_in_dbl;
    logic [2:0]  r_in_mode;
    logic        r_out_valid;
    logic [63:0] r_out_bits;
    logic [63:0] n_out_bits;
    logic        in_adv;

    // Hold the dynamic mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn_mode <= 3'd0;
        end else if (i_cfg_we) begin
            r_dyn_mode <= i_cfg_wdata;
        end
    end

    // Advance the input stage when the result stage can take it
    assign in_adv   = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_bits <= s_tdata;
            r_in_dbl  <= s_tuser[0];
            r_in_mode <= s_tuser[3:1];
        end
    end

    // Rounding datapath
    logic [2:0]  mode;
    logic [63:0] u;
    logic        sgn;
    logic [10:0] bexp;
    logic [11:0] e;
    logic        mag_zero;
    logic [5:0]  mbits;
    logic [5:0]  sh;
    logic [63:0] mmask;
    logic [63:0] frac;
    logic [63:0] half;
    logic [63:0] step;
    logic        away;
    logic [63:0] res;

    always_comb begin
        mode = (r_in_mode > 3'(fpri_pkg::MODE_RMM)) ? r_dyn_mode : r_in_mode;
        if (r_in_dbl) begin
            u        = r_in_bits;
            sgn      = u[63];
            bexp     = u[62:52];
            e        = {1'b0, bexp} - {1'b0, fpri_pkg::BIAS_D};
            mag_zero = (u[62:0] == 63'd0);
            mbits    = fpri_pkg::MBITS_D;
        end else begin
            u        = {32'd0, r_in_bits[31:0]};
            sgn      = u[31];
            bexp     = {3'd0, u[30:23]};
            e        = {1'b0, bexp} - {1'b0, fpri_pkg::BIAS_S};
            mag_zero = (u[30:0] == 31'd0);
            mbits    = fpri_pkg::MBITS_S;
        end
        sh    = e[5:0];
        mmask = ((64'd1 << mbits) - 64'd1) >> sh;
        frac  = u & mmask;
        half  = (64'd1 << (mbits - 6'd1)) >> sh;
        step  = (64'd1 << mbits) >> sh;
        away  = 1'b0;
        if (!e[11] && (e >= {6'd0, mbits}) || mag_zero) begin
            res = u;
        end else if (e[11]) begin
            // Magnitude below one: signed zero or signed one
            case (mode)
                3'(fpri_pkg::MODE_RNE): away = (e == 12'hFFF) &&
                                               ((u & ((64'd1 << mbits) - 64'd1)) != 64'd0);
                3'(fpri_pkg::MODE_RMM): away = (e == 12'hFFF);
                3'(fpri_pkg::MODE_RDN): away = sgn;
                3'(fpri_pkg::MODE_RUP): away = !sgn;
                default:                away = 1'b0;
            endcase
            if (r_in_dbl) begin
                res = {sgn, 63'd0} | (away ? fpri_pkg::ONE_D : 64'd0);
            end else begin
                res = {32'd0, sgn, 31'd0} | (away ? {32'd0, fpri_pkg::ONE_S} : 64'd0);
            end
        end else begin
            case (mode)
                3'(fpri_pkg::MODE_RNE): away = (frac > half) ||
                                               ((frac == half) && ((u & step) != 64'd0));
                3'(fpri_pkg::MODE_RMM): away = (frac >= half);
                3'(fpri_pkg::MODE_RDN): away = sgn && (frac != 64'd0);
                3'(fpri_pkg::MODE_RUP): away = !sgn && (frac != 64'd0);
                default:                away = 1'b0;
            endcase
            res = (u & ~mmask) + (away ? step : 64'd0);
            if (!r_in_dbl) begin
                res = {32'd0, res[31:0]};
            end
        end
        n_out_bits = res;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_out_bits <= n_out_bits;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_bits;

    // Checks
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_tready |=> r_out_valid && $stable(r_out_bits))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_tready)
        else $error("ready low with empty input stage");
    a_single_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv && !r_in_dbl |=> r_out_bits[63:32] == 32'd0)
        else $error("binary32 result upper bits set");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv |=> r_out_valid)
        else $error("advanced request lost");

endmodule

### bench/fp_round_to_integral_tb.sv
// Self-checking bench for fp_round_to_integral: predicts each rounding and checks the results.
module fp_round_to_integral_tb;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam logic [2:0] DYN_MODE = 3'd5;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] value_bits
    logic [3:0]  s_tuser;   // [0] is_double, [3:1] round_mode
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] rounded_bits

    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned result_count;
    bit          timed_out;
    bit          hold_off;

    fp_round_to_integral dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Report one mismatch and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Holds the dynamic mode and the queue of predicted rounded encodings
    class rounding_scoreboard;
        logic [2:0]  dyn_mode;
        logic [63:0] pending_rounded[$];

        function new();
            dyn_mode = 3'd0;
        endfunction

        // Round the encoding held in the low bits of u to an integral value
        function automatic logic [63:0] round_value(input logic [63:0] u, input bit dbl,
                                                    input logic [2:0] mode);
            int          mbits;
            int          expo;
            logic [63:0] sign_bit;
            logic [63:0] one_enc;
            logic [63:0] mant_mask;
            logic [63:0] frac;
            logic [63:0] half;
            logic [63:0] step;
            logic [63:0] sgn;
            bit          away;
            mbits = dbl ? 52 : 23;
            sign_bit = dbl ? 64'h8000000000000000 : 64'h80000000;
            one_enc = dbl ? fpri_pkg::ONE_D : {32'h0, fpri_pkg::ONE_S};
            expo = dbl ? int'(u[62:52]) - 1023 : int'(u[30:23]) - 127;
            mant_mask = (64'd1 << mbits) - 64'd1;
            sgn = u & sign_bit;
            away = 1'b0;
            if (expo >= mbits || (u & ~sign_bit) == 64'd0)
                return u;
            if (expo < 0) begin
                case (mode)
                    fpri_pkg::MODE_RNE: away = (expo == -1) && ((u & mant_mask) != 0);
                    fpri_pkg::MODE_RMM: away = (expo == -1);
                    fpri_pkg::MODE_RDN: away = (sgn != 0);
                    fpri_pkg::MODE_RUP: away = (sgn == 0);
                    default:            away = 1'b0;
                endcase
                return sgn | (away ? one_enc : 64'd0);
            end
            frac = u & (mant_mask >> expo);
            half = (64'd1 << (mbits - 1)) >> expo;
            step = (64'd1 << mbits) >> expo;
            case (mode)
                fpri_pkg::MODE_RNE: away = frac > half || (frac == half && (u & step) != 0);
                fpri_pkg::MODE_RMM: away = frac >= half;
                fpri_pkg::MODE_RDN: away = (sgn != 0) && (frac != 0);
                fpri_pkg::MODE_RUP: away = (sgn == 0) && (frac != 0);
                default:            away = 1'b0;
            endcase
            return (u - frac) + (away ? step : 64'd0);
        endfunction

        // Note an accepted request and queue its expected result
        function void note_request(input logic [63:0] bits, input logic [3:0] user);
            logic [2:0]  mode;
            logic [63:0] r;
            mode = user[3:1];
            if (mode > fpri_pkg::MODE_RMM)
                mode = dyn_mode;
            if (user[0])
                r = round_value(bits, 1'b1, mode);
            else
                r = round_value({32'h0, bits[31:0]}, 1'b0, mode) & 64'hFFFFFFFF;
            pending_rounded.push_back(r);
        endfunction

        // Check one result against the oldest expectation
        task check_result(input logic [63:0] got);
            logic [63:0] want;
            if (pending_rounded.size() == 0) begin
                report_mismatch("unexpected result", got, 64'h0);
            end else begin
                want = pending_rounded.pop_front();
                if (got !== want)
                    report_mismatch("rounded_bits", got, want);
            end
        endtask
    endclass

    rounding_scoreboard board;

    // Clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                board.note_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata);
                result_count++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Pick a gap length: mostly short, now and then long
    function automatic int unsigned gap_length();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(0, 3);
    endfunction

    // Receiver: random stalls, plus the long hold-off when asked
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
            if ($urandom_range(0, 2) == 0) begin
                gap = gap_length();
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            m_tready <= 1'b1;
        end
    end

    // Offer one request and hold it until accepted, then maybe idle
    task automatic send_request(input logic [63:0] bits, input bit dbl,
                                input logic [2:0] mode, input bit allow_gap);
        int unsigned gap;
        s_tdata <= bits;
        s_tuser <= {mode, dbl};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (allow_gap) begin
            gap = gap_length();
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                s_tdata <= {$urandom, $urandom};
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop sending and wait until every expected result is in
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_rounded.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_dyn_mode(input logic [2:0] m);
        i_cfg_wdata <= m;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.dyn_mode = m;
    endtask

    // Build a random encoding, biased toward exponents near the rounding range
    function automatic logic [63:0] random_value(input bit dbl);
        logic [63:0] v;
        int          e;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 8) begin
            if (dbl) begin
                e = 1023 + $urandom_range(0, 56) - 3;
                v[62:52] = e[10:0];
            end else begin
                e = 127 + $urandom_range(0, 27) - 3;
                v[30:23] = e[7:0];
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            if (dbl)
                v[51:0] = v[51:0] & ({52{1'b1}} << $urandom_range(0, 52));
            else
                v[22:0] = v[22:0] & ({23{1'b1}} << $urandom_range(0, 23));
        end
        return v;
    endfunction

    initial begin
        logic [63:0] directed[12];
        int unsigned i;
        int unsigned phase;
        bit          dbl;
        board = new();
        error_count = 0;
        idle_cycles = 0;
        result_count = 0;
        timed_out = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 3'd0;
        s_tvalid = 1'b0;
        s_tdata = 64'd0;
        s_tuser = 4'd0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: halves, ties, near-ones, zeros, inf, NaN, large, subnormal
        directed = '{64'hFFFFFFFF_3F000000, 64'h00000000_BF000000, 64'h00000000_3FC00000,
                     64'h00000000_40200000, 64'h00000000_4B7FFFFF, 64'h00000000_7FC12345,
                     64'h00000000_80000000, 64'h00000000_00000001, 64'h3FE0000000000000,
                     64'hBFF8000000000000, 64'h433FFFFFFFFFFFFF, 64'hFFF0000000000001};
        for (i = 0; i < 12; i++)
            send_request(directed[i], i >= 8, 3'(i % 8), 1'b0);
        send_request(64'h00000000_3F7FFFFF, 1'b0, fpri_pkg::MODE_RUP, 1'b1);
        send_request(64'h00000000_BE800000, 1'b0, fpri_pkg::MODE_RDN, 1'b1);
        send_request(64'h00000000_3F000000, 1'b0, fpri_pkg::MODE_RMM, 1'b1);
        send_request(64'h7FF0000000000000, 1'b1, fpri_pkg::MODE_RTZ, 1'b1);
        send_request(64'h8000000000000000, 1'b1, fpri_pkg::MODE_RNE, 1'b1);
        send_request(64'h0000000000000000, 1'b1, DYN_MODE, 1'b1);
        drain();

        // Random phases across dynamic-mode settings, out-of-range values too
        for (phase = 0; phase < 8; phase++) begin
            write_dyn_mode(3'(phase));
            if (phase == 3)
                hold_off = 1'b1;
            for (i = 0; i < RANDOM_ITEMS / 8; i++) begin
                dbl = 1'($urandom_range(0, 1));
                send_request(random_value(dbl), dbl, 3'($urandom_range(0, 7)),
                             phase != 3);
            end
            drain();
        end

        $display("covered %0d results over both precisions, all modes and dynamic settings 0..7",
                 result_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### sim.f
hdl/fpri_pkg.sv
hdl/fp_round_to_integral.sv
bench/fp_round_to_integral_tb.sv
